// ===== sv/vgts_pkg.sv =====
// ----------------------------------------------------------------------------
// vgts_pkg
// Shared types and constants for the trilinear grid sampler.
// ----------------------------------------------------------------------------
package vgts_pkg;

  localparam int GRID_BITS = 6;
  localparam int GRID_SIZE = 64;
  localparam int FRAC_BITS = 16;
  localparam int COMP_BITS = 24;
  localparam int POS_BITS  = 22;
  localparam int EXT_BITS  = 7;
  localparam int BANK_BITS = 3 * (GRID_BITS - 1);
  localparam int WORD_BITS = 3 * COMP_BITS;
  // interpolated values stay within the node range, one guard bit suffices
  localparam int ACC_BITS  = COMP_BITS + 1;

  typedef enum logic {OP_WRITE = 1'b0, OP_SAMPLE = 1'b1} op_t;

  typedef enum logic [1:0] {
    REG_EXTENT_X = 2'd0,
    REG_EXTENT_Y = 2'd1,
    REG_EXTENT_Z = 2'd2,
    REG_SPARE    = 2'd3
  } reg_idx_t;

  typedef logic signed [COMP_BITS-1:0] comp_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  // three blend components side by side
  typedef logic [2:0][ACC_BITS-1:0] acc3_t;

  typedef struct packed {
    logic                 write_en;
    logic [BANK_BITS-1:0] write_addr;
    logic [WORD_BITS-1:0] write_data;
    logic [2:0]           write_bank;
  } grid_write_t;

  // clamp an extent register to 2..GRID_SIZE and give (extent - 1) << FRAC
  function automatic logic [POS_BITS:0] limit_of(input logic [EXT_BITS-1:0] e);
    logic [EXT_BITS-1:0] c;
    c = e;
    if (e < EXT_BITS'(2)) c = EXT_BITS'(2);
    if (e > EXT_BITS'(GRID_SIZE)) c = EXT_BITS'(GRID_SIZE);
    return {(POS_BITS + 1 - EXT_BITS)'(0), c - EXT_BITS'(1)} << FRAC_BITS;
  endfunction

  // floor-shifted linear blend lo*(1-h)+hi*h = lo + (hi-lo)*h
  function automatic logic signed [ACC_BITS-1:0] lerp(
      input logic signed [ACC_BITS-1:0] lo, input logic signed [ACC_BITS-1:0] hi,
      input frac_t h);
    logic signed [ACC_BITS+FRAC_BITS+1:0] d;
    logic signed [ACC_BITS+FRAC_BITS+1:0] s;
    d = ($signed({{(FRAC_BITS+1){hi[ACC_BITS-1]}}, hi})
       - $signed({{(FRAC_BITS+1){lo[ACC_BITS-1]}}, lo}))
       * $signed({2'b00, {(ACC_BITS-1){1'b0}}, h});
    s = ($signed({{(FRAC_BITS+1){lo[ACC_BITS-1]}}, lo}) <<< FRAC_BITS) + d;
    return ACC_BITS'(s >>> FRAC_BITS);
  endfunction

endpackage

// ===== sv/vgts_if.sv =====
// ----------------------------------------------------------------------------
// vgts_req_if / vgts_res_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface vgts_req_if;
  import vgts_pkg::*;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [5:0] node_x;
  logic [5:0] node_y;
  logic [5:0] node_z;
  comp_t      value_x;
  comp_t      value_y;
  comp_t      value_z;
  logic [POS_BITS-1:0] pos_x;
  logic [POS_BITS-1:0] pos_y;
  logic [POS_BITS-1:0] pos_z;
  modport source (output valid, operation, node_x, node_y, node_z, value_x, value_y,
                  value_z, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, operation, node_x, node_y, node_z, value_x, value_y,
                value_z, pos_x, pos_y, pos_z, output ready);
endinterface

interface vgts_res_if;
  import vgts_pkg::*;
  logic  valid;
  logic  ready;
  comp_t sample_x;
  comp_t sample_y;
  comp_t sample_z;
  logic  out_of_range;
  modport source (output valid, sample_x, sample_y, sample_z, out_of_range, input ready);
  modport sink (input valid, sample_x, sample_y, sample_z, out_of_range, output ready);
endinterface

// ===== sv/vgts_bank.sv =====
// ----------------------------------------------------------------------------
// vgts_bank
// One parity bank of the grid store: one write port, one registered read.
// ----------------------------------------------------------------------------
module vgts_bank
  import vgts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [BANK_BITS-1:0] rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [BANK_BITS-1:0] wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [2**BANK_BITS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // read port, held while stalled
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/vgts_lerp_stage.sv =====
// ----------------------------------------------------------------------------
// vgts_lerp_stage
// Registered blend of one pair along one axis, three components.
// ----------------------------------------------------------------------------
module vgts_lerp_stage
  import vgts_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  acc3_t lo,
  input  acc3_t hi,
  input  frac_t h,
  output acc3_t q
);

  // one multiplier per component
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) q[c] <= lerp(lo[c], hi[c], h);
    end
  end

endmodule

// ===== sv/vector_grid_trilinear_sample_core.sv =====
// ----------------------------------------------------------------------------
// vector_grid_trilinear_sample_core
// Trilinear sampler over a 64^3 grid of three-component vectors.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid/ready   | operation, node, value, pos
//   res     | out | valid/ready   | sample_x/y/z, out_of_range
//   apb     | in  | psel/penable  | extent_x/y/z
//
// One request per cycle unless the output stalls; a sample result passes through
// bank read, x blend, y blend and z blend registers, with saturation on the output.
// Eight parity banks give all corners of a cell in one read.
// Writes give no result. Reset clears valid bits and sets extents to GRID_SIZE only.
// A stall freezes the whole pipe; ready follows the output stage.
// ----------------------------------------------------------------------------
module vector_grid_trilinear_sample_core
  import vgts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  vgts_req_if.sink    req,
  vgts_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NST = 4;

  logic [EXT_BITS-1:0] extent_x, extent_y, extent_z;
  logic                adv;
  logic [NST-1:0]      vld;
  reg_idx_t            rsel;

  assign rsel   = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign adv    = !vld[NST-1] || res.ready;
  assign req.ready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      extent_x <= EXT_BITS'(GRID_SIZE);
      extent_y <= EXT_BITS'(GRID_SIZE);
      extent_z <= EXT_BITS'(GRID_SIZE);
    end else if (psel && penable && pwrite) begin
      unique case (rsel)
        REG_EXTENT_X: extent_x <= pwdata[EXT_BITS-1:0];
        REG_EXTENT_Y: extent_y <= pwdata[EXT_BITS-1:0];
        REG_EXTENT_Z: extent_z <= pwdata[EXT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (rsel)
      REG_EXTENT_X: prdata = {25'd0, extent_x};
      REG_EXTENT_Y: prdata = {25'd0, extent_y};
      REG_EXTENT_Z: prdata = {25'd0, extent_z};
      default:      prdata = '0;
    endcase
  end

  // stage 0: decode, range check, bank addressing
  logic acc, is_samp;
  logic oor0;
  logic [GRID_BITS-1:0] xi, yi, zi;
  logic [BANK_BITS-1:0] rd_addr [8];
  grid_write_t wr;

  assign acc     = req.valid && adv;
  assign is_samp = req.operation == OP_SAMPLE;
  assign xi = req.pos_x[FRAC_BITS +: GRID_BITS];
  assign yi = req.pos_y[FRAC_BITS +: GRID_BITS];
  assign zi = req.pos_z[FRAC_BITS +: GRID_BITS];
  assign oor0 = ({1'b0, req.pos_x} >= limit_of(extent_x))
             || ({1'b0, req.pos_y} >= limit_of(extent_y))
             || ({1'b0, req.pos_z} >= limit_of(extent_z));

  // bank (px,py,pz) holds nodes of that parity; along each axis the corner
  // held by bank p is i + (p ^ i[0]), stored at half its index
  always_comb begin
    logic [GRID_BITS-1:0] ax, ay, az;
    for (int b = 0; b < 8; b++) begin
      ax = (xi + GRID_BITS'(b[0] ^ xi[0])) >> 1;
      ay = (yi + GRID_BITS'(b[1] ^ yi[0])) >> 1;
      az = (zi + GRID_BITS'(b[2] ^ zi[0])) >> 1;
      rd_addr[b] = {az[GRID_BITS-2:0], ay[GRID_BITS-2:0], ax[GRID_BITS-2:0]};
    end
  end

  always_comb begin
    wr.write_en   = acc && !is_samp;
    wr.write_bank = {req.node_z[0], req.node_y[0], req.node_x[0]};
    wr.write_addr = {req.node_z[GRID_BITS-1:1], req.node_y[GRID_BITS-1:1],
                     req.node_x[GRID_BITS-1:1]};
    wr.write_data = {req.value_z, req.value_y, req.value_x};
  end

  logic [WORD_BITS-1:0] bank_q [8];
  for (genvar b = 0; b < 8; b++) begin : g_bank
    vgts_bank u_bank (
      .clk     (clk),
      .rd_en   (adv),
      .rd_addr (rd_addr[b]),
      .rd_data (bank_q[b]),
      .wr_en   (wr.write_en && wr.write_bank == 3'(b)),
      .wr_addr (wr.write_addr),
      .wr_data (wr.write_data)
    );
  end

  // valid and side-band pipeline
  logic [NST-1:0] oor;
  logic par_x, par_y, par_z;
  frac_t hx, hy [2], hz [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], acc && is_samp};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor   <= {oor[NST-2:0], oor0};
      par_x <= xi[0];
      par_y <= yi[0];
      par_z <= zi[0];
      hx    <= req.pos_x[FRAC_BITS-1:0];
      hy[0] <= req.pos_y[FRAC_BITS-1:0];
      hy[1] <= hy[0];
      hz[0] <= req.pos_z[FRAC_BITS-1:0];
      hz[1] <= hz[0];
      hz[2] <= hz[1];
    end
  end

  // stage 1 -> 2: unscramble corners and blend along x
  acc3_t xlo [4], xhi [4], xq [4];
  always_comb begin
    logic [2:0] lb, hb;
    for (int k = 0; k < 4; k++) begin
      // corner (dx,dy,dz) lives in bank parity (x^dx, y^dy, z^dz)
      lb = {(par_z ^ k[1]), (par_y ^ k[0]), par_x};
      hb = {(par_z ^ k[1]), (par_y ^ k[0]), !par_x};
      for (int c = 0; c < 3; c++) begin
        xlo[k][c] = ACC_BITS'($signed(bank_q[lb][c*COMP_BITS +: COMP_BITS]));
        xhi[k][c] = ACC_BITS'($signed(bank_q[hb][c*COMP_BITS +: COMP_BITS]));
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lerp_x
    vgts_lerp_stage u_lerp_x (
      .clk(clk), .en(adv), .lo(xlo[k]), .hi(xhi[k]), .h(hx), .q(xq[k])
    );
  end

  // stage 2 -> 3: blend along y
  acc3_t yq [2];
  for (genvar j = 0; j < 2; j++) begin : g_lerp_y
    vgts_lerp_stage u_lerp_y (
      .clk(clk), .en(adv), .lo(xq[2*j]), .hi(xq[2*j+1]), .h(hy[1]), .q(yq[j])
    );
  end

  // stage 3 -> 4: blend along z
  acc3_t zq;
  vgts_lerp_stage u_lerp_z (
    .clk(clk), .en(adv), .lo(yq[0]), .hi(yq[1]), .h(hz[2]), .q(zq)
  );

  // saturate, and zero out-of-range samples
  function automatic comp_t sat(input logic signed [ACC_BITS-1:0] v);
    if (v > $signed(ACC_BITS'({1'b0, {(COMP_BITS-1){1'b1}}}))) return {1'b0, {(COMP_BITS-1){1'b1}}};
    if (v < $signed({2'b11, {(COMP_BITS-1){1'b0}}})) return {1'b1, {(COMP_BITS-1){1'b0}}};
    return v[COMP_BITS-1:0];
  endfunction

  assign res.valid        = vld[NST-1];
  assign res.out_of_range = oor[NST-1];
  assign res.sample_x     = oor[NST-1] ? '0 : sat(zq[0]);
  assign res.sample_y     = oor[NST-1] ? '0 : sat(zq[1]);
  assign res.sample_z     = oor[NST-1] ? '0 : sat(zq[2]);

`ifndef ASSERT_OFF
  // a write never enters the result pipe
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.operation == OP_WRITE) |=> !vld[0])
    else $error("write created a result");
  // a stalled result stays in place
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.sample_x)))
    else $error("stalled result changed");
  // no request is accepted while the output is stalled
  a_adv: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && !res.ready) |-> !req.ready)
    else $error("accepted while output stalled");
  // out of range gives zero samples; x and z are checked
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.out_of_range) |-> (res.sample_x == '0 && res.sample_z == '0))
    else $error("out of range sample non-zero");
`endif

endmodule
